// ----- rtl/core/nae_pkg.sv -----
// shared types, constants and helper functions for the angular error pipeline
package nae_pkg;

  localparam int NREG = 6;
  localparam int SQ_STEPS = 32;
  localparam int DIV_STEPS = 30;
  localparam int CORDIC_STEPS = 30;

  localparam logic [2:0] REG_ROW0_COLS01 = 3'd0;
  localparam logic [2:0] REG_ROW0_COLS23 = 3'd1;
  localparam logic [2:0] REG_ROW1_COLS01 = 3'd2;
  localparam logic [2:0] REG_ROW1_COLS23 = 3'd3;
  localparam logic [2:0] REG_ROW2_COLS01 = 3'd4;
  localparam logic [2:0] REG_ROW2_COLS23 = 3'd5;

  localparam logic [63:0] RST_ROW0_COLS01 = 64'h0000_0000_0100_0000;
  localparam logic [63:0] RST_ROW0_COLS23 = 64'h0;
  localparam logic [63:0] RST_ROW1_COLS01 = 64'h0100_0000_0000_0000;
  localparam logic [63:0] RST_ROW1_COLS23 = 64'h0;
  localparam logic [63:0] RST_ROW2_COLS01 = 64'h0;
  localparam logic [63:0] RST_ROW2_COLS23 = 64'h0000_0000_0100_0000;

  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;
  localparam logic [60:0] ONE_Q60 = 61'h1000_0000_0000_0000;

  typedef struct packed {
    logic signed [31:0] image_x;
    logic signed [31:0] image_y;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } pt_t;

  typedef struct packed {
    logic [30:0] angle;
    logic        degenerate;
  } err_t;

  // row, column pair, 64-bit register
  typedef logic [2:0][1:0][63:0] pose_t;

  // normalized vectors out of the front end
  typedef struct packed {
    logic [2:0][29:0] tm;
    logic [2:0]       tn;
    logic [2:0][29:0] rm;
    logic [2:0]       rn;
    logic             degen;
  } nv_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [34:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [61:0] den;
    logic [29:0] q;
  } dv_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
  } cr_t;

  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] r;
    case (i)
      5'd0:  r = 31'd843314857;
      5'd1:  r = 31'd497837830;
      5'd2:  r = 31'd263043837;
      5'd3:  r = 31'd133525159;
      5'd4:  r = 31'd67021687;
      5'd5:  r = 31'd33543516;
      5'd6:  r = 31'd16775851;
      5'd7:  r = 31'd8388437;
      5'd8:  r = 31'd4194283;
      5'd9:  r = 31'd2097149;
      5'd10: r = 31'd1048576;
      5'd11: r = 31'd524288;
      5'd12: r = 31'd262144;
      5'd13: r = 31'd131072;
      5'd14: r = 31'd65536;
      5'd15: r = 31'd32768;
      5'd16: r = 31'd16384;
      5'd17: r = 31'd8192;
      5'd18: r = 31'd4096;
      5'd19: r = 31'd2048;
      5'd20: r = 31'd1024;
      5'd21: r = 31'd512;
      5'd22: r = 31'd256;
      5'd23: r = 31'd128;
      5'd24: r = 31'd64;
      5'd25: r = 31'd32;
      5'd26: r = 31'd16;
      5'd27: r = 31'd8;
      5'd28: r = 31'd4;
      5'd29: r = 31'd2;
      default: r = 31'd0;
    endcase
    return r;
  endfunction

  // position of the highest set bit, zero for a zero word
  function automatic logic [5:0] lead64(input logic [63:0] v);
    logic [5:0] r;
    r = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

  // bring a magnitude to the scale where bit p lands on bit 29
  function automatic logic [29:0] norm30(input logic [63:0] m, input logic [5:0] p);
    logic [63:0] s;
    if (p >= 6'd29) s = m >> (p - 6'd29);
    else s = m << (6'd29 - p);
    return s[29:0];
  endfunction

endpackage

// ----- rtl/core/normalized_angular_error.sv -----
// top level: angular reprojection error pipeline with pose registers
// One point word enters per cycle and one error word leaves per cycle while
// the output does not stall; the whole path is a single pipeline of 137
// stages. The front end transforms the world point by the 3x4 pose and
// scales both vectors by powers of two; then two root chains of 32 cells
// give the vector lengths, a 30-cell restoring divider gives |cos| in Q1.30,
// a 32-cell root chain gives the sine, and a 30-cell cordic chain gives the
// angle. Every cell advances together; a stall at the output freezes the
// whole row, and pt_ready follows err_ready through the output register.
// Pose registers must be written through wr_en/wr_index/wr_data only while
// the block is idle; the block itself does not enforce this. Indexes past
// the sixth register are ignored. A camera point of zero length reports
// degenerate with angle zero.
module normalized_angular_error (
  input  logic           clk,
  input  logic           rst,
  input  logic           pt_valid,
  output logic           pt_ready,
  input  nae_pkg::pt_t   pt,
  output logic           err_valid,
  input  logic           err_ready,
  output nae_pkg::err_t  err,
  input  logic           wr_en,
  input  logic [2:0]     wr_index,
  input  logic [63:0]    wr_data
);
  import nae_pkg::*;

  typedef struct packed {
    logic        degen;
    logic        dneg;
    logic [61:0] mag;
  } sd1_t;

  typedef struct packed {
    logic degen;
    logic dneg;
    logic sat;
  } sd2_t;

  typedef struct packed {
    logic        degen;
    logic        dneg;
    logic [30:0] cq;
  } sd3_t;

  typedef struct packed {
    logic degen;
    logic dneg;
  } sd4_t;

  // whole row moves when the output word is free or being taken
  logic  adv;
  pose_t pose;

  logic  fv;
  nv_t   fd;

  // squares and cross products
  logic        vm;
  logic [59:0] rr [3];
  logic [59:0] tt [3];
  logic [59:0] rt [3];
  logic [2:0]  pneg;
  logic        dgm;

  logic signed [62:0] dot_c;
  logic [62:0]        dabs_c;

  // root chains for both lengths
  logic  v1 [SQ_STEPS+1];
  sd1_t  s1 [SQ_STEPS+1];
  sq_t   sqa [SQ_STEPS+1];
  sq_t   sqb [SQ_STEPS+1];

  // length product
  logic        vd;
  logic [61:0] den_d;
  sd1_t        sdd;

  // divider chain
  logic  v2 [DIV_STEPS+1];
  sd2_t  s2 [DIV_STEPS+1];
  dv_t   dv [DIV_STEPS+1];

  // cosine squared
  logic        vc;
  logic [30:0] cq_c;
  logic [61:0] csq_c;
  sd2_t        sdc;

  // sine root chain
  logic  v3 [SQ_STEPS+1];
  sd3_t  s3 [SQ_STEPS+1];
  sq_t   sqc [SQ_STEPS+1];

  // cordic chain
  logic  v4 [CORDIC_STEPS+1];
  sd4_t  s4 [CORDIC_STEPS+1];
  cr_t   cr [CORDIC_STEPS+1];

  logic signed [32:0] zf;
  logic [31:0]        zc;
  logic [31:0]        af;
  logic [32:0]        ar;

  assign adv = !err_valid || err_ready;
  assign pt_ready = adv;

  // pose registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pose[0][0] <= RST_ROW0_COLS01;
      pose[0][1] <= RST_ROW0_COLS23;
      pose[1][0] <= RST_ROW1_COLS01;
      pose[1][1] <= RST_ROW1_COLS23;
      pose[2][0] <= RST_ROW2_COLS01;
      pose[2][1] <= RST_ROW2_COLS23;
    end else if (wr_en && (wr_index <= REG_ROW2_COLS23)) begin
      pose[wr_index[2:1]][wr_index[0]] <= wr_data;
    end
  end

  nae_front u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .pt_valid (pt_valid && pt_ready),
    .pt       (pt),
    .pose     (pose),
    .nv_valid (fv),
    .nv       (fd)
  );

  // signed dot product from the three cross terms
  always_comb begin
    dot_c = 63'sd0;
    for (int k = 0; k < 3; k++) begin
      if (pneg[k]) dot_c = dot_c - $signed({3'b000, rt[k]});
      else dot_c = dot_c + $signed({3'b000, rt[k]});
    end
    dabs_c = dot_c[62] ? 63'(-dot_c) : 63'(dot_c);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        rr[k] <= 60'(fd.rm[k] * fd.rm[k]);
        tt[k] <= 60'(fd.tm[k] * fd.tm[k]);
        rt[k] <= 60'(fd.rm[k] * fd.tm[k]);
      end
      pneg <= fd.rn ^ fd.tn;
      dgm <= fd.degen;

      sqa[0].rad <= {2'b00, 62'(rr[0]) + 62'(rr[1]) + 62'(rr[2])};
      sqa[0].rem <= 35'd0;
      sqa[0].root <= 32'd0;
      sqb[0].rad <= {2'b00, 62'(tt[0]) + 62'(tt[1]) + 62'(tt[2])};
      sqb[0].rem <= 35'd0;
      sqb[0].root <= 32'd0;
      s1[0].degen <= dgm;
      s1[0].dneg <= dot_c[62];
      s1[0].mag <= dabs_c[61:0];

      den_d <= 62'(sqa[SQ_STEPS].root[30:0] * sqb[SQ_STEPS].root[30:0]);
      sdd <= s1[SQ_STEPS];

      dv[0].rem <= {2'b00, sdd.mag};
      dv[0].den <= den_d;
      dv[0].q <= 30'd0;
      s2[0].degen <= sdd.degen;
      s2[0].dneg <= sdd.dneg;
      // cosine at or past one saturates
      s2[0].sat <= (den_d == 62'd0) || (sdd.mag >= den_d);

      cq_c <= s2[DIV_STEPS].sat ? ONE_Q30 : {1'b0, dv[DIV_STEPS].q};
      csq_c <= s2[DIV_STEPS].sat ? {1'b0, ONE_Q60}
             : 62'(dv[DIV_STEPS].q * dv[DIV_STEPS].q);
      sdc <= s2[DIV_STEPS];

      sqc[0].rad <= {3'b000, ONE_Q60 - csq_c[60:0]};
      sqc[0].rem <= 35'd0;
      sqc[0].root <= 32'd0;
      s3[0].degen <= sdc.degen;
      s3[0].dneg <= sdc.dneg;
      s3[0].cq <= cq_c;

      cr[0].x <= $signed({3'b000, s3[SQ_STEPS].cq});
      cr[0].y <= $signed({3'b000, sqc[SQ_STEPS].root[30:0]});
      cr[0].z <= 33'sd0;
      s4[0].degen <= s3[SQ_STEPS].degen;
      s4[0].dneg <= s3[SQ_STEPS].dneg;

      for (int k = 0; k < SQ_STEPS; k++) begin
        s1[k+1] <= s1[k];
        s3[k+1] <= s3[k];
      end
      for (int k = 0; k < DIV_STEPS; k++) s2[k+1] <= s2[k];
      for (int k = 0; k < CORDIC_STEPS; k++) s4[k+1] <= s4[k];
    end
  end

  // valid line alongside the data row
  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
      vd <= 1'b0;
      vc <= 1'b0;
      for (int k = 0; k <= SQ_STEPS; k++) begin
        v1[k] <= 1'b0;
        v3[k] <= 1'b0;
      end
      for (int k = 0; k <= DIV_STEPS; k++) v2[k] <= 1'b0;
      for (int k = 0; k <= CORDIC_STEPS; k++) v4[k] <= 1'b0;
      err_valid <= 1'b0;
    end else if (adv) begin
      vm <= fv;
      v1[0] <= vm;
      vd <= v1[SQ_STEPS];
      v2[0] <= vd;
      vc <= v2[DIV_STEPS];
      v3[0] <= vc;
      v4[0] <= v3[SQ_STEPS];
      for (int k = 0; k < SQ_STEPS; k++) begin
        v1[k+1] <= v1[k];
        v3[k+1] <= v3[k];
      end
      for (int k = 0; k < DIV_STEPS; k++) v2[k+1] <= v2[k];
      for (int k = 0; k < CORDIC_STEPS; k++) v4[k+1] <= v4[k];
      err_valid <= v4[CORDIC_STEPS];
    end
  end

  genvar g;
  for (g = 0; g < SQ_STEPS; g++) begin : g_sq
    nae_sqrt_cell u_sqa (.clk(clk), .en(adv), .d(sqa[g]), .q(sqa[g+1]));
    nae_sqrt_cell u_sqb (.clk(clk), .en(adv), .d(sqb[g]), .q(sqb[g+1]));
    nae_sqrt_cell u_sqc (.clk(clk), .en(adv), .d(sqc[g]), .q(sqc[g+1]));
  end

  for (g = 0; g < DIV_STEPS; g++) begin : g_div
    nae_div_cell u_div (.clk(clk), .en(adv), .d(dv[g]), .q(dv[g+1]));
  end

  for (g = 0; g < CORDIC_STEPS; g++) begin : g_cor
    nae_cordic_cell u_cor (
      .clk  (clk),
      .en   (adv),
      .step (5'(g)),
      .d    (cr[g]),
      .q    (cr[g+1])
    );
  end

  // clamp to [0, pi/2], fold for obtuse angles, halve to Q2.29
  always_comb begin
    zf = cr[CORDIC_STEPS].z;
    if (zf < 0) zc = 32'd0;
    else if (zf > $signed({1'b0, HALF_PI_Q30})) zc = HALF_PI_Q30;
    else zc = zf[31:0];
    af = s4[CORDIC_STEPS].dneg ? (PI_Q30 - zc) : zc;
    ar = {1'b0, af} + 33'd1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      err.degenerate <= s4[CORDIC_STEPS].degen;
      err.angle <= s4[CORDIC_STEPS].degen ? 31'd0 : ar[31:1];
    end
  end

  // degenerate words carry a zero angle
  assert property (@(posedge clk) disable iff (rst)
    err_valid && err.degenerate |-> err.angle == 31'd0)
    else $error("degenerate word with nonzero angle");

  // angle never exceeds pi in Q2.29
  assert property (@(posedge clk) disable iff (rst)
    err_valid |-> err.angle <= 31'd1686629713)
    else $error("angle out of range");

  // cosine entering the sine root is at most one
  assert property (@(posedge clk) disable iff (rst)
    v3[0] |-> s3[0].cq <= ONE_Q30)
    else $error("cosine above one");

  // a stalled row keeps its valid line frozen
  assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v4[0]) && $stable(vd))
    else $error("pipeline moved during stall");
endmodule

// ----- rtl/core/nae_sqrt_cell.sv -----
// one digit step of the integer square root chain
module nae_sqrt_cell (
  input  logic          clk,
  input  logic          en,
  input  nae_pkg::sq_t  d,
  output nae_pkg::sq_t  q
);
  import nae_pkg::*;

  logic [34:0] r2;
  logic [34:0] trial;
  sq_t         nxt;

  always_comb begin
    r2 = {d.rem[32:0], d.rad[63:62]};
    trial = {1'b0, d.root, 2'b01};
    nxt.rad = {d.rad[61:0], 2'b00};
    if (r2 >= trial) begin
      nxt.rem = r2 - trial;
      nxt.root = {d.root[30:0], 1'b1};
    end else begin
      nxt.rem = r2;
      nxt.root = {d.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= nxt;
  end
endmodule

// ----- rtl/core/nae_div_cell.sv -----
// one quotient bit of the restoring divider chain
module nae_div_cell (
  input  logic          clk,
  input  logic          en,
  input  nae_pkg::dv_t  d,
  output nae_pkg::dv_t  q
);
  import nae_pkg::*;

  logic [63:0] r2;
  dv_t         nxt;

  always_comb begin
    r2 = {d.rem[62:0], 1'b0};
    nxt.den = d.den;
    if (r2 >= {2'b00, d.den}) begin
      nxt.rem = r2 - {2'b00, d.den};
      nxt.q = {d.q[28:0], 1'b1};
    end else begin
      nxt.rem = r2;
      nxt.q = {d.q[28:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= nxt;
  end
endmodule

// ----- rtl/core/nae_cordic_cell.sv -----
// one rotation of the vectoring cordic chain
module nae_cordic_cell (
  input  logic          clk,
  input  logic          en,
  input  logic [4:0]    step,
  input  nae_pkg::cr_t  d,
  output nae_pkg::cr_t  q
);
  import nae_pkg::*;

  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [32:0] ang;
  cr_t                nxt;

  always_comb begin
    dx = d.y >>> step;
    dy = d.x >>> step;
    ang = $signed({2'b00, atan_q30(step)});
    if (d.y < 0) begin
      nxt.x = d.x - dx;
      nxt.y = d.y + dy;
      nxt.z = d.z - ang;
    end else begin
      nxt.x = d.x + dx;
      nxt.y = d.y - dy;
      nxt.z = d.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= nxt;
  end
endmodule

// ----- rtl/core/nae_front.sv -----
// point transform, magnitude split and power-of-two normalization
module nae_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           pt_valid,
  input  nae_pkg::pt_t   pt,
  input  nae_pkg::pose_t pose,
  output logic           nv_valid,
  output nae_pkg::nv_t   nv
);
  import nae_pkg::*;

  logic signed [31:0] coef [3][4];
  logic signed [31:0] w [3];

  logic               v1, v2, v3, v4;
  logic signed [63:0] prod1 [3][3];
  logic signed [31:0] tr1 [3];
  logic signed [31:0] ix1, iy1, ix2, iy2;
  logic signed [65:0] sum2 [3];
  logic [63:0]        tm3 [3];
  logic [2:0]         tn3, tn4;
  logic [31:0]        rm3 [2];
  logic [1:0]         rn3, rn4;
  logic [63:0]        tm4 [3];
  logic [31:0]        rm4 [2];
  logic [5:0]         lt4, lr4;
  logic               dg3, dg4;
  logic [65:0]        abs3 [3];

  genvar r;
  for (r = 0; r < 3; r++) begin : g_coef
    assign coef[r][0] = pose[r][0][31:0];
    assign coef[r][1] = pose[r][0][63:32];
    assign coef[r][2] = pose[r][1][31:0];
    assign coef[r][3] = pose[r][1][63:32];
  end

  assign w[0] = pt.world_x;
  assign w[1] = pt.world_y;
  assign w[2] = pt.world_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      abs3[k] = sum2[k][65] ? -sum2[k] : sum2[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      nv_valid <= 1'b0;
    end else if (adv) begin
      v1 <= pt_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      nv_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // products of the rotation part, translation kept aside
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) prod1[i][j] <= coef[i][j] * w[j];
        tr1[i] <= coef[i][3];
      end
      ix1 <= pt.image_x;
      iy1 <= pt.image_y;
      // camera point in Q.40
      for (int i = 0; i < 3; i++) begin
        sum2[i] <= 66'(prod1[i][0]) + 66'(prod1[i][1]) + 66'(prod1[i][2])
                 + (66'(tr1[i]) <<< 16);
      end
      ix2 <= ix1;
      iy2 <= iy1;
      // sign and magnitude
      for (int i = 0; i < 3; i++) begin
        tn3[i] <= sum2[i][65];
        tm3[i] <= abs3[i][63:0];
      end
      dg3 <= (abs3[0][63:0] == 64'd0) && (abs3[1][63:0] == 64'd0)
          && (abs3[2][63:0] == 64'd0);
      rn3 <= {iy2[31], ix2[31]};
      rm3[0] <= ix2[31] ? 32'(-ix2) : 32'(ix2);
      rm3[1] <= iy2[31] ? 32'(-iy2) : 32'(iy2);
      // leading bit of the largest component
      tm4 <= tm3;
      rm4 <= rm3;
      tn4 <= tn3;
      rn4 <= rn3;
      dg4 <= dg3;
      lt4 <= lead64(tm3[0] | tm3[1] | tm3[2]);
      lr4 <= lead64({32'd0, rm3[0] | rm3[1] | 32'h0100_0000});
      // shift so the largest component lands in [2^29, 2^30)
      for (int i = 0; i < 3; i++) nv.tm[i] <= norm30(tm4[i], lt4);
      nv.rm[0] <= norm30({32'd0, rm4[0]}, lr4);
      nv.rm[1] <= norm30({32'd0, rm4[1]}, lr4);
      nv.rm[2] <= norm30(64'h0100_0000, lr4);
      nv.tn <= tn4;
      nv.rn <= {1'b0, rn4};
      nv.degen <= dg4;
    end
  end
endmodule
